// ----- rtl/core/stn_pkg.sv -----
// ---------------------------------------------------------------------------
// stn_pkg
// types, character constants and per-byte step functions for the normaliser
// ---------------------------------------------------------------------------
`default_nettype none

package stn_pkg;

    localparam int RES_MAX = 6;
    localparam int RES_CNT_W = 3;
    localparam int TAIL_W = 21;

    // ascii characters, 7 bits
    localparam logic [6:0] CH_NUL    = 7'h00;
    localparam logic [6:0] CH_SPACE  = 7'h20;
    localparam logic [6:0] CH_DASH   = 7'h2d;
    localparam logic [6:0] CH_SLASH  = 7'h2f;
    localparam logic [6:0] CH_APOS   = 7'h27;
    localparam logic [6:0] CH_BQUOTE = 7'h60;
    localparam logic [6:0] CH_LOWER_A = 7'h61;
    localparam logic [6:0] CH_LOWER_E = 7'h65;
    localparam logic [6:0] CH_LOWER_I = 7'h69;
    localparam logic [6:0] CH_LOWER_O = 7'h6f;
    localparam logic [6:0] CH_LOWER_R = 7'h72;
    localparam logic [6:0] CH_LOWER_S = 7'h73;
    localparam logic [6:0] CH_LOWER_T = 7'h74;
    localparam logic [6:0] CH_LOWER_U = 7'h75;
    localparam logic [6:0] CH_CASE_BIT = 7'h20;

    localparam logic [TAIL_W-1:0] SUFFIX_STR = {CH_LOWER_S, CH_LOWER_T, CH_LOWER_R};

    // utf-8 lead and continuation bytes of interest
    localparam logic [7:0] LEAD_C2 = 8'hc2;
    localparam logic [7:0] LEAD_C3 = 8'hc3;
    localparam logic [7:0] LEAD_E2 = 8'he2;
    localparam logic [7:0] CONT_ACUTE = 8'hb4;
    localparam logic [7:0] CONT_80 = 8'h80;
    localparam logic [7:0] CONT_LQUOTE = 8'h98;
    localparam logic [7:0] CONT_RQUOTE = 8'h99;

    typedef struct packed {
        logic [7:0]        lead;        // held utf-8 lead byte
        logic [1:0]        pcount;      // held bytes, 0..2
        logic              space_held;
        logic              at_start;
        logic [TAIL_W-1:0] tail;        // last three token characters
        logic [1:0]        tlen;        // token length, saturating at 3
    } state_t;

    typedef struct packed {
        logic [6:0] ch;
        logic       valid;
        logic       last;
    } result_t;

    typedef result_t [RES_MAX-1:0] result_vec_t;

    typedef struct packed {
        state_t                 st;
        result_vec_t            res;
        logic [RES_CNT_W-1:0]   cnt;
    } work_t;

    localparam state_t STATE_RESET = '{
        lead: 8'h00, pcount: 2'd0, space_held: 1'b0, at_start: 1'b1,
        tail: '0, tlen: 2'd0
    };

    // second byte after c3: {first, second}, first zero for a single vowel
    function automatic logic [13:0] latin_map(input logic [7:0] b);
        logic [13:0] m;
        case (b)
            8'h84, 8'ha4: m = {CH_LOWER_A, CH_LOWER_E};
            8'h96, 8'hb6: m = {CH_LOWER_O, CH_LOWER_E};
            8'h9c, 8'hbc: m = {CH_LOWER_U, CH_LOWER_E};
            8'h9f:        m = {CH_LOWER_S, CH_LOWER_S};
            8'h89, 8'ha9, 8'h88, 8'ha8, 8'h8a, 8'haa: m = {CH_NUL, CH_LOWER_E};
            8'h81, 8'ha1, 8'h80, 8'ha0, 8'h82, 8'ha2: m = {CH_NUL, CH_LOWER_A};
            8'h8d, 8'had, 8'h8c, 8'hac, 8'h8e, 8'hae: m = {CH_NUL, CH_LOWER_I};
            8'h93, 8'hb3, 8'h92, 8'hb2, 8'h94, 8'hb4: m = {CH_NUL, CH_LOWER_O};
            8'h9a, 8'hba, 8'h99, 8'hb9, 8'h9b, 8'hbb: m = {CH_NUL, CH_LOWER_U};
            default:      m = '0;
        endcase
        return m;
    endfunction

    function automatic work_t push_res(input work_t w, input logic [6:0] ch,
                                       input logic vld);
        work_t r;
        r = w;
        if (r.cnt < RES_CNT_W'(RES_MAX))
        begin
            r.res[r.cnt].ch = ch;
            r.res[r.cnt].valid = vld;
            r.res[r.cnt].last = 1'b0;
            r.cnt = r.cnt + RES_CNT_W'(1);
        end
        return r;
    endfunction

    function automatic work_t emit_char(input work_t w, input logic [6:0] c);
        work_t r;
        r = w;
        if (r.st.space_held)
        begin
            r = push_res(r, CH_SPACE, 1'b1);
            r.st.space_held = 1'b0;
        end
        r = push_res(r, c, 1'b1);
        r.st.at_start = 1'b0;
        r.st.tail = {r.st.tail[TAIL_W-8:0], c};
        if (r.st.tlen != 2'd3)
            r.st.tlen = r.st.tlen + 2'd1;
        return r;
    endfunction

    function automatic work_t close_token(input work_t w);
        work_t r;
        r = w;
        if (r.st.tlen == 2'd3 && r.st.tail == SUFFIX_STR)
        begin
            r = push_res(r, CH_LOWER_A, 1'b1);
            r = push_res(r, CH_LOWER_S, 1'b1);
            r = push_res(r, CH_LOWER_S, 1'b1);
            r = push_res(r, CH_LOWER_E, 1'b1);
        end
        r.st.tail = '0;
        r.st.tlen = 2'd0;
        return r;
    endfunction

    function automatic work_t separator(input work_t w);
        work_t r;
        r = close_token(w);
        if (!r.st.at_start)
            r.st.space_held = 1'b1;
        return r;
    endfunction

    function automatic work_t fresh_byte(input work_t w, input logic [7:0] b);
        work_t r;
        logic [6:0] c;
        r = w;
        c = b[6:0];
        if (!b[7])
        begin
            if (c inside {[7'h41:7'h5a]})
                r = emit_char(r, c | CH_CASE_BIT);
            else if (c inside {[7'h61:7'h7a], [7'h30:7'h39], CH_DASH, CH_SLASH})
                r = emit_char(r, c);
            else if (c == CH_APOS || c == CH_BQUOTE)
                r = r;
            else
                r = separator(r);
        end
        else if (b inside {LEAD_C2, LEAD_C3, LEAD_E2})
        begin
            r.st.lead = b;
            r.st.pcount = 2'd1;
        end
        else
        begin
            r = separator(r);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/stn_step.sv -----
// ---------------------------------------------------------------------------
// stn_step
// one input byte against the current state: next state and up to six results
// ---------------------------------------------------------------------------
`default_nettype none

module stn_step (
    input  wire logic [7:0]          in_byte,
    input  wire logic                end_of_text,
    input  wire stn_pkg::state_t     cur_state,
    output stn_pkg::state_t          next_state,
    output stn_pkg::result_vec_t     results,
    output logic [stn_pkg::RES_CNT_W-1:0] result_count
);
    import stn_pkg::*;

    work_t w;
    logic [13:0] m;

    always_comb
    begin
        w.st = cur_state;
        w.res = '0;
        w.cnt = '0;
        m = (cur_state.lead == LEAD_C3) ? latin_map(in_byte) : 14'd0;

        if (cur_state.pcount == 2'd1)
        begin
            if (cur_state.lead == LEAD_C2 && in_byte == CONT_ACUTE)
            begin
                w.st.lead = '0;
                w.st.pcount = 2'd0;
            end
            else if (m != 14'd0)
            begin
                w.st.lead = '0;
                w.st.pcount = 2'd0;
                if (m[13:7] != CH_NUL)
                    w = emit_char(w, m[13:7]);
                w = emit_char(w, m[6:0]);
            end
            else if (cur_state.lead == LEAD_E2 && in_byte == CONT_80)
            begin
                w.st.pcount = 2'd2;
            end
            else
            begin
                w.st.lead = '0;
                w.st.pcount = 2'd0;
                w = separator(w);
                w = fresh_byte(w, in_byte);
            end
        end
        else if (cur_state.pcount == 2'd2)
        begin
            w.st.lead = '0;
            w.st.pcount = 2'd0;
            if (in_byte != CONT_LQUOTE && in_byte != CONT_RQUOTE)
            begin
                w = separator(w);
                w = fresh_byte(w, in_byte);
            end
        end
        else
        begin
            w.st.lead = '0;
            w.st.pcount = 2'd0;
            w = fresh_byte(w, in_byte);
        end

        if (end_of_text)
        begin
            // a cut sequence counts as a separator
            if (w.st.pcount != 2'd0)
                w = separator(w);
            w = close_token(w);
            if (w.cnt == '0)
                w = push_res(w, CH_NUL, 1'b0);
            w.res[w.cnt - RES_CNT_W'(1)].last = 1'b1;
            w.st = STATE_RESET;
        end
    end

    assign next_state = w.st;
    assign results = w.res;
    assign result_count = w.cnt;

endmodule

`default_nettype wire

// ----- rtl/core/search_text_normalizer.sv -----
// ---------------------------------------------------------------------------
// search_text_normalizer
// utf-8 search text in, lowercase ascii tokens out, one byte per request
// ---------------------------------------------------------------------------
//
//  channel   dir  tdata                           tuser        tlast
//  s_axis    in   [7:0] in_byte                   -            end_of_text
//  m_axis    out  [6:0] out_char, [7] zero        char_valid   last_of_text
//
//  one byte is taken per cycle while each byte gives at most one result and m_axis does not stall
//  a byte giving n results (space, umlaut pair, suffix) holds s_axis_tready
//  low while the rest queue behind the single-result output register
//  the burst buffer drains in order; input is taken only once it is empty
//  reset clears the text state, the burst count and the output valid
//  stalls on m_axis hold the output register; input still enters while a
//  result waits, as long as the burst buffer is empty
//
`default_nettype none

module search_text_normalizer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tlast,   // end_of_text
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [6:0] out_char, [7] zero fill
    output logic            m_axis_tuser,   // [0] char_valid
    output logic            m_axis_tlast    // last_of_text
);
    import stn_pkg::*;

    // text state carried between bytes
    state_t state_reg, state_next;

    // output register
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;

    // results still waiting behind the output register
    result_vec_t          burst_reg, burst_next;
    logic [RES_CNT_W-1:0] burst_cnt_reg, burst_cnt_next;

    // step results for the byte on the input
    state_t               step_state;
    result_vec_t          step_res;
    logic [RES_CNT_W-1:0] step_cnt;

    logic accept;
    logic out_load;

    stn_step u_step (
        .in_byte      (s_axis_tdata),
        .end_of_text  (s_axis_tlast),
        .cur_state    (state_reg),
        .next_state   (step_state),
        .results      (step_res),
        .result_count (step_cnt)
    );

    assign s_axis_tready = (burst_cnt_reg == '0);
    assign accept = s_axis_tvalid && s_axis_tready;
    // output register free now or emptied this cycle
    assign out_load = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg;
        out_data_next = out_data_reg;
        burst_next = burst_reg;
        burst_cnt_next = burst_cnt_reg;

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        if (accept)
        begin
            state_next = step_state;
            if (out_load && step_cnt != '0)
            begin
                // first result straight to the output, the rest queue up
                out_data_next = step_res[0];
                out_valid_next = 1'b1;
                burst_next = step_res >> $bits(result_t);
                burst_cnt_next = step_cnt - RES_CNT_W'(1);
            end
            else
            begin
                burst_next = step_res;
                burst_cnt_next = step_cnt;
            end
        end
        else if (burst_cnt_reg != '0 && out_load)
        begin
            out_data_next = burst_reg[0];
            out_valid_next = 1'b1;
            burst_next = burst_reg >> $bits(result_t);
            burst_cnt_next = burst_cnt_reg - RES_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
            out_valid_reg <= 1'b0;
            burst_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            burst_cnt_reg <= burst_cnt_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        burst_reg <= burst_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {1'b0, out_data_reg.ch};
    assign m_axis_tuser = out_data_reg.valid;
    assign m_axis_tlast = out_data_reg.last;

endmodule

`default_nettype wire

// ----- rtl/core/stn_checker.sv -----
// ---------------------------------------------------------------------------
// stn_checker
// port-level checks on the normaliser output stream
// ---------------------------------------------------------------------------
`default_nettype none

module stn_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tuser,
    input wire logic       m_axis_tlast
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output request dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output payload changed while stalled");

    // an empty marker only closes a text
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("empty result not marked last");

    // an empty marker carries a zero character
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 8'h00)
        else $error("empty result carries a character");

    // no uppercase letter ever leaves
    a_no_upper: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |->
            !(m_axis_tdata[6:0] >= 7'h41 && m_axis_tdata[6:0] <= 7'h5a))
        else $error("uppercase character on output");

endmodule

bind search_text_normalizer stn_checker u_stn_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ----- tb/search_text_normalizer_tb.sv -----
// ---------------------------------------------------------------------------
// search_text_normalizer_tb
// streams utf-8 texts through the normaliser and checks every output request
// against a cycle-free prediction of the lowercase token text
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module search_text_normalizer_tb;

    // one input request: a text byte and its end-of-text flag
    typedef struct packed {
        logic [7:0] data;
        logic       eot;
    } text_byte_t;

    // one predicted output request
    typedef struct packed {
        logic [6:0] ch;
        logic       valid;
        logic       last;
    } norm_char_t;

    localparam int IDLE_PCT = 34;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic       s_axis_tlast = 1'b0;    // end_of_text
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [6:0] out_char, [7] zero fill
    logic       m_axis_tuser;           // [0] char_valid
    logic       m_axis_tlast;           // last_of_text

    // stimulus and scoreboard
    text_byte_t text_bytes_q[$];
    norm_char_t expected_chars[$];
    logic       byte_taken = 1'b0;
    int         bytes_sent = 0;
    int         texts_done = 0;
    int         chars_checked = 0;
    int         mismatches = 0;
    logic       calm;

    // predictor state, mirrors the normaliser between input requests
    logic [7:0]  held_lead;
    logic [1:0]  held_cnt;
    logic        gap_pending;
    logic        fresh_text;
    logic [20:0] word_tail;
    logic [1:0]  word_len;

    // results of the byte being predicted
    norm_char_t  step_res[stn_pkg::RES_MAX];
    int          step_n;

    search_text_normalizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 clk = ~clk;

    // no idling on either side over a stretch in the middle of the run
    assign calm = (bytes_sent >= 140) && (bytes_sent < 220);

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    task automatic clear_text_state();
        held_lead   = 8'h00;
        held_cnt    = 2'd0;
        gap_pending = 1'b0;
        fresh_text  = 1'b1;
        word_tail   = '0;
        word_len    = 2'd0;
    endtask

    task automatic put_char(input logic [6:0] c, input logic v);
        if (step_n < stn_pkg::RES_MAX)
        begin
            step_res[step_n] = '{ch: c, valid: v, last: 1'b0};
            step_n++;
        end
    endtask

    // a character of the current word, preceded by the held space if any
    task automatic add_letter(input logic [6:0] c);
        if (gap_pending)
        begin
            put_char(stn_pkg::CH_SPACE, 1'b1);
            gap_pending = 1'b0;
        end
        put_char(c, 1'b1);
        fresh_text = 1'b0;
        word_tail = {word_tail[13:0], c};
        if (word_len != 2'd3)
            word_len = word_len + 2'd1;
    endtask

    // close the word: street abbreviation gets its suffix
    task automatic finish_word();
        if (word_len == 2'd3 && word_tail == stn_pkg::SUFFIX_STR)
        begin
            put_char(stn_pkg::CH_LOWER_A, 1'b1);
            put_char(stn_pkg::CH_LOWER_S, 1'b1);
            put_char(stn_pkg::CH_LOWER_S, 1'b1);
            put_char(stn_pkg::CH_LOWER_E, 1'b1);
        end
        word_tail = '0;
        word_len = 2'd0;
    endtask

    task automatic word_break();
        finish_word();
        if (!fresh_text)
            gap_pending = 1'b1;
    endtask

    // second byte after c3, folded on the low five bits since upper and
    // lower case differ only in bit 5; {first, second}, first zero if single
    function automatic logic [13:0] fold_c3(input logic [7:0] b);
        logic [6:0] v1;
        logic [6:0] v2;
        v1 = '0;
        v2 = '0;
        if (b[7:6] == 2'b10)
        begin
            case (b[4:0])
                5'h00, 5'h01, 5'h02: v2 = stn_pkg::CH_LOWER_A;
                5'h04:
                begin
                    v1 = stn_pkg::CH_LOWER_A;
                    v2 = stn_pkg::CH_LOWER_E;
                end
                5'h08, 5'h09, 5'h0a: v2 = stn_pkg::CH_LOWER_E;
                5'h0c, 5'h0d, 5'h0e: v2 = stn_pkg::CH_LOWER_I;
                5'h12, 5'h13, 5'h14: v2 = stn_pkg::CH_LOWER_O;
                5'h16:
                begin
                    v1 = stn_pkg::CH_LOWER_O;
                    v2 = stn_pkg::CH_LOWER_E;
                end
                5'h19, 5'h1a, 5'h1b: v2 = stn_pkg::CH_LOWER_U;
                5'h1c:
                begin
                    v1 = stn_pkg::CH_LOWER_U;
                    v2 = stn_pkg::CH_LOWER_E;
                end
                5'h1f:
                begin
                    // sharp s only in the upper half, the lower one is y diaeresis
                    if (!b[5])
                    begin
                        v1 = stn_pkg::CH_LOWER_S;
                        v2 = stn_pkg::CH_LOWER_S;
                    end
                end
                default: v2 = '0;
            endcase
        end
        return {v1, v2};
    endfunction

    // a byte with nothing held before it
    task automatic take_plain(input logic [7:0] b);
        if (!b[7])
        begin
            if (b >= 8'h41 && b <= 8'h5a)
                add_letter(b[6:0] | stn_pkg::CH_CASE_BIT);
            else if ((b >= 8'h61 && b <= 8'h7a) || (b >= 8'h30 && b <= 8'h39) ||
                     b[6:0] == stn_pkg::CH_DASH || b[6:0] == stn_pkg::CH_SLASH)
                add_letter(b[6:0]);
            else if (b[6:0] != stn_pkg::CH_APOS && b[6:0] != stn_pkg::CH_BQUOTE)
                word_break();
        end
        else if (b == stn_pkg::LEAD_C2 || b == stn_pkg::LEAD_C3 || b == stn_pkg::LEAD_E2)
        begin
            held_lead = b;
            held_cnt = 2'd1;
        end
        else
        begin
            word_break();
        end
    endtask

    // work out the output requests of one accepted byte
    task automatic predict_text_byte(input logic [7:0] b, input logic eot);
        logic [13:0] m;
        step_n = 0;
        if (held_cnt == 2'd1)
        begin
            m = (held_lead == stn_pkg::LEAD_C3) ? fold_c3(b) : '0;
            if (held_lead == stn_pkg::LEAD_C2 && b == stn_pkg::CONT_ACUTE)
            begin
                held_cnt = 2'd0;
                held_lead = 8'h00;
            end
            else if (m != '0)
            begin
                held_cnt = 2'd0;
                held_lead = 8'h00;
                if (m[13:7] != '0)
                    add_letter(m[13:7]);
                add_letter(m[6:0]);
            end
            else if (held_lead == stn_pkg::LEAD_E2 && b == stn_pkg::CONT_80)
            begin
                held_cnt = 2'd2;
            end
            else
            begin
                // broken sequence: the lead splits, the new byte is looked at again
                held_cnt = 2'd0;
                held_lead = 8'h00;
                word_break();
                take_plain(b);
            end
        end
        else if (held_cnt == 2'd2)
        begin
            held_cnt = 2'd0;
            held_lead = 8'h00;
            if (b != stn_pkg::CONT_LQUOTE && b != stn_pkg::CONT_RQUOTE)
            begin
                word_break();
                take_plain(b);
            end
        end
        else
        begin
            take_plain(b);
        end

        if (eot)
        begin
            // a sequence cut off by the end of the text counts as a separator
            if (held_cnt != 2'd0)
                word_break();
            finish_word();
            if (step_n == 0)
                put_char(stn_pkg::CH_NUL, 1'b0);
            step_res[step_n-1].last = 1'b1;
            clear_text_state();
        end

        for (int i = 0; i < step_n; i++)
            expected_chars.insert(expected_chars.size(), step_res[i]);
    endtask

    task automatic report(input string what, input norm_char_t want);
        mismatches++;
        $display("mismatch at %0t: %s, got char %h valid %b last %b, want %h %b %b",
                 $realtime, what, m_axis_tdata[6:0], m_axis_tuser, m_axis_tlast,
                 want.ch, want.valid, want.last);
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // directed text given right-aligned in a byte vector, first byte on top
    task automatic push_text(input logic [8*16-1:0] bytes, input int n);
        for (int i = 0; i < n; i++)
            text_bytes_q.insert(text_bytes_q.size(),
                                '{data: bytes[8*(n-1-i) +: 8], eot: (i == n - 1)});
    endtask

    // random text, mostly well-formed words and utf-8 sequences with some noise
    task automatic add_random_text();
        logic [7:0] seq[$];
        int n;
        int pick;
        n = $urandom_range(12, 1);
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
                seq.insert(seq.size(),
                           8'($urandom_range(25)) + ($urandom_range(1) ? 8'h41 : 8'h61));
            else if (pick < 45)
                seq.insert(seq.size(), 8'h30 + 8'($urandom_range(9)));
            else if (pick < 50)
                seq.insert(seq.size(), $urandom_range(1) ? 8'h2d : 8'h2f);
            else if (pick < 58)
            begin
                case ($urandom_range(4))
                    0: seq.insert(seq.size(), 8'h20);
                    1: seq.insert(seq.size(), 8'h27);
                    2: seq.insert(seq.size(), 8'h60);
                    3: seq.insert(seq.size(), 8'h2e);
                    default: seq.insert(seq.size(), 8'h2c);
                endcase
            end
            else if (pick < 72)
            begin
                seq.insert(seq.size(), stn_pkg::LEAD_C3);
                seq.insert(seq.size(), 8'($urandom_range(8'hbf, 8'h80)));
            end
            else if (pick < 76)
            begin
                seq.insert(seq.size(), stn_pkg::LEAD_C2);
                seq.insert(seq.size(), $urandom_range(2) != 0 ? stn_pkg::CONT_ACUTE
                                                              : 8'($urandom_range(255)));
            end
            else if (pick < 80)
            begin
                seq.insert(seq.size(), stn_pkg::LEAD_E2);
                if ($urandom_range(4) != 0)
                begin
                    seq.insert(seq.size(), stn_pkg::CONT_80);
                    case ($urandom_range(2))
                        0: seq.insert(seq.size(), stn_pkg::CONT_LQUOTE);
                        1: seq.insert(seq.size(), stn_pkg::CONT_RQUOTE);
                        default: seq.insert(seq.size(), 8'($urandom_range(255)));
                    endcase
                end
                else
                begin
                    seq.insert(seq.size(), 8'($urandom_range(255)));
                end
            end
            else if (pick < 86)
            begin
                // street abbreviation, in either case
                seq.insert(seq.size(), $urandom_range(1) ? 8'h73 : 8'h53);
                seq.insert(seq.size(), 8'h74);
                seq.insert(seq.size(), 8'h72);
            end
            else
            begin
                seq.insert(seq.size(), 8'($urandom_range(255)));
            end
        end
        foreach (seq[i])
            text_bytes_q.insert(text_bytes_q.size(),
                                '{data: seq[i], eot: (i == seq.size() - 1)});
    endtask

    // ------------------------------------------------------------------
    // driver: new request at the falling edge once the last one was taken
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : driver
        text_byte_t nb;
        if (rst_n)
        begin
            if (!s_axis_tvalid || byte_taken)
            begin
                if (text_bytes_q.size() != 0 &&
                    (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    nb = text_bytes_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nb.data;
                    s_axis_tlast  <= nb.eot;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on accepted input, check each accepted output
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        norm_char_t want;
        if (rst_n)
        begin
            byte_taken <= s_axis_tvalid && s_axis_tready;
            // prediction goes first so that the oldest expectation stays in front
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_text_byte(s_axis_tdata, s_axis_tlast);
                bytes_sent++;
                if (s_axis_tlast)
                    texts_done++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_chars.size() == 0)
                begin
                    report("output with nothing expected", '0);
                end
                else
                begin
                    want = expected_chars.pop_front();
                    chars_checked++;
                    if (m_axis_tdata[6:0] !== want.ch || m_axis_tuser !== want.valid ||
                        m_axis_tlast !== want.last)
                        report("wrong output", want);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence of the run
    // ------------------------------------------------------------------
    initial
    begin
        clear_text_state();

        // letters of both cases, digits, dash, slash, dropped apostrophe,
        // a space and a street abbreviation closed by a full stop
        push_text({8'h5a, 8'h61, 8'h2d, 8'h2f, 8'h30, 8'h39,
                   8'h27, 8'h20, 8'h53, 8'h74, 8'h72, 8'h2e}, 12);
        // umlaut, sharp s, curly apostrophe, acute accent, broken c3 lead,
        // and a quote sequence cut off by the end of the text
        push_text({8'hc3, 8'ha4, 8'hc3, 8'h9f, 8'he2, 8'h80, 8'h99,
                   8'hc2, 8'hb4, 8'hc3, 8'h41, 8'he2, 8'h80}, 13);
        // a text that gives no character at all
        push_text({8'hff}, 1);

        while (text_bytes_q.size() < 330)
            add_random_text();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (text_bytes_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("%0d bytes in %0d texts normalised, %0d output characters compared",
                 bytes_sent, texts_done, chars_checked);
        if (mismatches == 0)
            $display("[search_text_normalizer] OK");
        else
            $display("[search_text_normalizer] ERROR");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("timeout with %0d outputs still expected", expected_chars.size());
        $display("[search_text_normalizer] ERROR");
        $finish;
    end

endmodule
